@@ sv/assert_macros.svh @@
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

@@ sv/qpud_pkg.sv @@
package qpud_pkg;

  localparam int unsigned KEY_MAX = 8;
  localparam int unsigned KEY_POS_W = $clog2(KEY_MAX + 1);
  localparam int unsigned KEY_SEL_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] VALUE_MAX = 9'd256;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] HEX_TEN = 8'h0A;

  typedef enum logic [1:0] {
    MODE_MATCH,
    MODE_SKIP,
    MODE_VALUE,
    MODE_DONE
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_FOUND,
    KIND_MISSING
  } kind_e;

  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_FOUND,
    TERM_MISSING
  } term_e;

  // results of one input byte: kept value bytes, then an optional closing result
  typedef struct packed {
    logic [2:0][7:0]    bytes;
    logic [1:0]         nbytes;
    logic [COUNT_W-1:0] base;
    term_e              term;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61) v = c - 8'h61 + HEX_TEN;
    else if (c >= 8'h41) v = c - 8'h41 + HEX_TEN;
    else v = c - 8'h30;
    return v[3:0];
  endfunction

endpackage

@@ sv/qpud_fifo.sv @@
`include "assert_macros.svh"

module qpud_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qpud_pkg::cmd_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output qpud_pkg::cmd_t data_o,
  output logic           full_o
);
  import qpud_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, push_i && full_o && !pop_i, "queue written while full")
  `ASSERT_NEVER(a_fifo_underflow, pop_i && !valid_o, "queue read while empty")

endmodule

@@ sv/qpud_front.sv @@
`include "assert_macros.svh"

module qpud_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  input  logic [63:0]                   key_chars_i,
  input  logic [3:0]                    key_length_i,
  input  logic [qpud_pkg::COUNT_W-1:0]  max_length_i,
  output logic                          push_o,
  output qpud_pkg::cmd_t                cmd_o
);
  import qpud_pkg::*;

  mode_e                mode_q, mode_d;
  logic [KEY_POS_W-1:0] kp_q, kp_d;
  logic [1:0]           pc_q, pc_d;
  logic [7:0]           pb_q, pb_d;
  logic [COUNT_W-1:0]   vc_q, vc_d;

  logic [KEY_MAX-1:0][7:0] key_bytes;
  logic [KEY_POS_W-1:0]    klen;
  logic                    key_hit, b_hex, b_pct, b_amp, b_plus, b_eq, enter_value;

  logic [2:0][7:0]    att;
  logic [1:0]         n_att;
  logic               fin, do_plain, missing;
  logic [1:0]         npc;
  logic [COUNT_W-1:0] lim, base, room;
  logic [1:0]         kept;
  term_e              term;

  assign key_bytes = key_chars_i[KEY_MAX*8-1:0];

  // byte classification
  always_comb begin
    klen = (key_length_i > 4'(KEY_MAX)) ? KEY_POS_W'(KEY_MAX) : KEY_POS_W'(key_length_i);
    key_hit = (in_byte_i == key_bytes[kp_q[KEY_SEL_W-1:0]]);
    b_hex  = is_hex(in_byte_i);
    b_pct  = (in_byte_i == CH_PCT);
    b_amp  = (in_byte_i == CH_AMP);
    b_plus = (in_byte_i == CH_PLUS);
    b_eq   = (in_byte_i == CH_EQ);
    enter_value = (mode_q == MODE_MATCH) && !b_amp && (kp_q >= klen) && b_eq;
  end

  // results of this byte: candidate value bytes, then the limit cut
  always_comb begin
    att      = '0;
    n_att    = '0;
    fin      = 1'b0;
    do_plain = 1'b0;
    npc      = pc_q;
    if (mode_q == MODE_VALUE) begin
      unique case (pc_q)
        2'd1: begin
          if (b_hex) begin
            npc = 2'd2;
          end else begin
            att[n_att] = CH_PCT;
            n_att = n_att + 1'b1;
            do_plain = 1'b1;
          end
        end
        2'd2: begin
          npc = 2'd0;
          if (b_hex) begin
            att[n_att] = {hex_nib(pb_q), hex_nib(in_byte_i)};
            n_att = n_att + 1'b1;
          end else begin
            att[n_att] = CH_PCT;
            n_att = n_att + 1'b1;
            att[n_att] = pb_q;
            n_att = n_att + 1'b1;
            do_plain = 1'b1;
          end
        end
        default: do_plain = 1'b1;
      endcase
      if (do_plain) begin
        npc = 2'd0;
        if (b_pct) begin
          npc = 2'd1;
        end else if (b_amp) begin
          fin = 1'b1;
        end else begin
          att[n_att] = b_plus ? CH_SPACE : in_byte_i;
          n_att = n_att + 1'b1;
        end
      end
      // held escape at end of string goes out literally
      if (in_last_i && !fin) begin
        if (npc != 2'd0) begin
          att[n_att] = CH_PCT;
          n_att = n_att + 1'b1;
        end
        if (npc == 2'd2) begin
          att[n_att] = in_byte_i;
          n_att = n_att + 1'b1;
        end
        fin = 1'b1;
      end
    end else if (enter_value && in_last_i) begin
      fin = 1'b1;
    end
    missing = in_last_i && !enter_value &&
              (mode_q == MODE_MATCH || mode_q == MODE_SKIP);

    lim  = (max_length_i > VALUE_MAX) ? VALUE_MAX : max_length_i;
    base = (mode_q == MODE_VALUE) ? vc_q : '0;
    room = (base >= lim) ? '0 : lim - base;
    kept = (room < COUNT_W'(n_att)) ? room[1:0] : n_att;

    if (fin) term = TERM_FOUND;
    else if (missing) term = TERM_MISSING;
    else term = TERM_NONE;

    cmd_o.bytes  = att;
    cmd_o.nbytes = kept;
    cmd_o.base   = base;
    cmd_o.term   = term;
    push_o = accept_i && ((kept != '0) || (term != TERM_NONE));
  end

  // parse state
  always_comb begin
    mode_d = mode_q;
    kp_d   = kp_q;
    pc_d   = pc_q;
    pb_d   = pb_q;
    vc_d   = vc_q;
    if (accept_i) begin
      unique case (mode_q)
        MODE_MATCH: begin
          if (b_amp) begin
            kp_d = '0;
          end else if (kp_q < klen) begin
            if (key_hit) kp_d = kp_q + 1'b1;
            else mode_d = MODE_SKIP;
          end else if (b_eq) begin
            mode_d = MODE_VALUE;
            vc_d   = '0;
            pc_d   = '0;
          end else begin
            mode_d = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (b_amp) begin
            mode_d = MODE_MATCH;
            kp_d   = '0;
          end
        end
        MODE_VALUE: begin
          pc_d = npc;
          if (npc == 2'd2) pb_d = in_byte_i;
          vc_d = vc_q + COUNT_W'(kept);
          if (fin) mode_d = MODE_DONE;
        end
        MODE_DONE: ;
      endcase
      if (in_last_i) begin
        mode_d = MODE_MATCH;
        kp_d   = '0;
        pc_d   = '0;
        pb_d   = '0;
        vc_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MATCH;
      kp_q   <= '0;
      pc_q   <= '0;
      pb_q   <= '0;
      vc_q   <= '0;
    end else begin
      mode_q <= mode_d;
      kp_q   <= kp_d;
      pc_q   <= pc_d;
      pb_q   <= pb_d;
      vc_q   <= vc_d;
    end
  end

  `ASSERT_ALWAYS(a_pend_in_value, (pc_q != 2'd0) |-> (mode_q == MODE_VALUE),
                 "escape held outside a value")
  `ASSERT_ALWAYS(a_count_cap, vc_q <= VALUE_MAX, "value count beyond the cap")

endmodule

@@ sv/qpud_back.sv @@
`include "assert_macros.svh"

module qpud_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  qpud_pkg::cmd_t                head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_kind_o,
  output logic [7:0]                    out_byte_o,
  output logic [qpud_pkg::COUNT_W-1:0]  out_count_o,
  output logic                          out_last_o
);
  import qpud_pkg::*;

  logic [1:0]         idx_q, idx_d;
  logic               valid_q, valid_d;
  kind_e              kind_q, kind_d;
  logic [7:0]         byte_q, byte_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               last_q, last_d;
  logic [2:0]         total;
  logic               load;

  always_comb begin
    total  = {1'b0, head_i.nbytes} + ((head_i.term != TERM_NONE) ? 3'd1 : 3'd0);
    load   = head_valid_i && (!valid_q || out_ready_i);
    last_d = ({1'b0, idx_q} == total - 3'd1);
    pop_o  = load && last_d;
    if (idx_q < head_i.nbytes) begin
      kind_d  = KIND_BYTE;
      byte_d  = head_i.bytes[idx_q];
      count_d = head_i.base + COUNT_W'(idx_q) + 1'b1;
    end else begin
      kind_d  = (head_i.term == TERM_MISSING) ? KIND_MISSING : KIND_FOUND;
      byte_d  = '0;
      count_d = (head_i.term == TERM_MISSING) ? '0 : head_i.base + COUNT_W'(head_i.nbytes);
    end
    idx_d = idx_q;
    if (load) idx_d = last_d ? '0 : idx_q + 1'b1;
    if (load) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
    else valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;
  assign out_count_o = count_q;
  assign out_last_o  = last_q;

  `ASSERT_ALWAYS(a_mid_entry, (idx_q != 2'd0) |-> head_valid_i, "entry left half sent")
  `ASSERT_ALWAYS(a_byte_count, (valid_q && kind_q == KIND_BYTE) |-> (count_q != '0),
                 "value byte with zero count")

endmodule

@@ sv/query_param_url_decoder_core.sv @@
// Query parameter decoder: takes a query string one byte per transfer on
// in_*, with in_last_i on the final byte, and returns the URL-decoded value
// of the first '&'-separated segment whose name equals the configured key
// followed by '='. "%XX" with two hex digits becomes one byte, '+' becomes a
// space, a '%' without two hex digits is passed on literally. Each value byte
// comes out as kind 0 with the running count; kind 1 closes the value with
// the count (capped at max_length, at most 256); kind 2 with count 0 says no
// segment matched. out_last_o marks the final result of one input byte.
// Input bytes are taken one per cycle whenever the two-entry queue between
// the parser and the result sequencer has room; a byte yields zero to four
// results and the sequencer sends one result per cycle while out_ready_i
// is high, so new bytes are taken while earlier results still wait. The
// configuration port is a plain write port; write it only while idle.
module query_param_url_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [qpud_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  // query bytes
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          in_last_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_kind_o,
  output logic [7:0]                    out_byte_o,
  output logic [qpud_pkg::COUNT_W-1:0]  out_count_o,
  output logic                          out_last_o
);
  import qpud_pkg::*;

  logic [63:0]        key_chars_q;
  logic [3:0]         key_length_q;
  logic [COUNT_W-1:0] max_length_q;

  logic accept, push, q_valid, q_full, pop;
  cmd_t push_cmd, head_cmd;

  // configuration registers, reset to the key "url" with a 256 byte cap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_chars_q  <= 64'h0000_0000_006C_7275;
      key_length_q <= 4'd3;
      max_length_q <= VALUE_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_CHARS:  key_chars_q  <= cfg_data_i;
        CFG_KEY_LENGTH: key_length_q <= cfg_data_i[3:0];
        CFG_MAX_LENGTH: max_length_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // a byte is taken whenever the queue can hold its results
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // parser: key match, escape handling, count cap
  qpud_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .key_chars_i  (key_chars_q),
    .key_length_i (key_length_q),
    .max_length_i (max_length_q),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // bytes with no results never enter the queue
  qpud_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_cmd),
    .full_o  (q_full)
  );

  // sequencer: one result per cycle into the output register unless out_ready_i holds it
  qpud_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .out_count_o  (out_count_o),
    .out_last_o   (out_last_o)
  );

endmodule
